[hdl/assert_macros.svh]
// assertion macros shared by the include-directive scanner rtl
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

[hdl/ssids_pkg.sv]
// shared types, codes and constants of the include-directive scanner
// no dependencies; imported by every scanner module
`default_nettype none

package ssids_pkg;

   // longest stored tag name
   localparam int NAME_MAX  = 64;
   localparam int CNT_W     = $clog2(NAME_MAX + 1);
   localparam int AVAIL_W   = CNT_W + 2;
   localparam int LEN_W     = 7;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // result kinds
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_NAME    = 2'd1;
   localparam logic [1:0] KIND_CLOSE   = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // characters
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_GT    = 8'h3E;

   localparam logic [2:0] OPEN_LAST = 3'd4;
   localparam logic [1:0] DASH_FULL = 2'd2;

   // byte i of the opener "<!--#"
   function automatic logic [7:0] opener_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_LT;
         3'd1:    b = CH_BANG;
         3'd2:    b = CH_DASH;
         3'd3:    b = CH_DASH;
         3'd4:    b = CH_HASH;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // one item's worth of results, in emit order:
   // pre run, main result, flush run, end marker
   typedef struct packed {
      logic [2:0]       pre_cnt;    // held bytes released first
      logic             pre_dash;   // 1 dashes as name bytes, 0 opener bytes as content
      logic             main_vld;
      logic [1:0]       main_kind;
      logic [7:0]       main_byte;
      logic [LEN_W-1:0] main_len;
      logic             main_ovf;
      logic [2:0]       flush_cnt;  // held bytes flushed as content at end
      logic             flush_dash; // 1 dashes, 0 opener bytes
      logic             end_mark;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/ssids_front.sv]
// front part: accepts bytes, tracks opener/closer matching, builds commands
// depends on ssids_pkg and assert_macros.svh
`default_nettype none

module ssids_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_eoc,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   output ssids_pkg::cmd_type     cmd,
   output logic                   cmd_vld
);
   import ssids_pkg::*;
`include "assert_macros.svh"

   logic               enable_ff, enable_in;
   logic               in_tag_ff, in_tag_in;
   logic [2:0]         open_ff, open_in;
   logic [1:0]         dash_ff, dash_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;

   logic [AVAIL_W-1:0] avail;
   logic [AVAIL_W-1:0] need;

   always_comb begin
      avail = AVAIL_W'(NAME_MAX) - AVAIL_W'(count_ff);
      need  = AVAIL_W'(dash_ff) + AVAIL_W'(1);

      enable_in = csr_wr_en ? csr_wr_data : enable_ff;
      in_tag_in = in_tag_ff;
      open_in   = open_ff;
      dash_in   = dash_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      cmd       = '0;

      if (!enable_ff) begin
         cmd.main_vld  = 1'b1;
         cmd.main_kind = KIND_CONTENT;
         cmd.main_byte = in_byte;
      end else if (in_tag_ff) begin
         if (in_byte == CH_DASH) begin
            if (dash_ff != DASH_FULL) begin
               dash_in = dash_ff + 2'd1;
            end else if (avail != '0) begin
               cmd.main_vld  = 1'b1;
               cmd.main_kind = KIND_NAME;
               cmd.main_byte = CH_DASH;
               count_in      = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end else if (in_byte == CH_GT && dash_ff == DASH_FULL) begin
            cmd.main_vld  = 1'b1;
            cmd.main_kind = KIND_CLOSE;
            cmd.main_len  = LEN_W'(count_ff);
            cmd.main_ovf  = ovf_ff;
            in_tag_in     = 1'b0;
            dash_in       = '0;
            count_in      = '0;
            ovf_in        = 1'b0;
         end else begin
            // held dashes then this byte, as name bytes while room is left
            cmd.pre_dash = 1'b1;
            dash_in      = '0;
            if (avail >= need) begin
               cmd.pre_cnt   = 3'(dash_ff);
               cmd.main_vld  = 1'b1;
               cmd.main_kind = KIND_NAME;
               cmd.main_byte = in_byte;
               count_in      = count_ff + CNT_W'(need);
            end else begin
               cmd.pre_cnt = 3'(avail);
               count_in    = count_ff + CNT_W'(avail);
               ovf_in      = 1'b1;
            end
         end
      end else begin
         if (in_byte == opener_byte(open_ff)) begin
            if (open_ff == OPEN_LAST) begin
               in_tag_in = 1'b1;
               open_in   = '0;
               dash_in   = '0;
               count_in  = '0;
               ovf_in    = 1'b0;
            end else begin
               open_in = open_ff + 3'd1;
            end
         end else begin
            cmd.pre_cnt = open_ff;
            if (in_byte == CH_LT) begin
               open_in = 3'd1;
            end else begin
               open_in       = '0;
               cmd.main_vld  = 1'b1;
               cmd.main_kind = KIND_CONTENT;
               cmd.main_byte = in_byte;
            end
         end
      end

      // end of content: flush what is still held, then the end marker
      if (in_eoc) begin
         cmd.flush_dash = in_tag_in;
         cmd.flush_cnt  = in_tag_in ? 3'(dash_in) : open_in;
         cmd.end_mark   = 1'b1;
         in_tag_in      = 1'b0;
         open_in        = '0;
         dash_in        = '0;
         count_in       = '0;
         ovf_in         = 1'b0;
      end

      cmd_vld = accept && (cmd.pre_cnt != '0 || cmd.main_vld || cmd.end_mark);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         in_tag_ff <= 1'b0;
         open_ff   <= '0;
         dash_ff   <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         if (accept) begin
            in_tag_ff <= in_tag_in;
            open_ff   <= open_in;
            dash_ff   <= dash_in;
            count_ff  <= count_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   `ASSERT_ALWAYS(a_open_bound, clock, reset, open_ff <= OPEN_LAST)
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(NAME_MAX))
   `ASSERT_NEVER(a_text_clean, clock, reset,
                 !in_tag_ff && (dash_ff != '0 || count_ff != '0 || ovf_ff))

endmodule

`default_nettype wire

[hdl/ssids_cmd_queue.sv]
// short command queue between scanner front and back, register based
// depends on ssids_pkg and assert_macros.svh
`default_nettype none

module ssids_cmd_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  ssids_pkg::cmd_type push_cmd,
   output logic               full,
   input  wire logic          pop,
   output ssids_pkg::cmd_type head,
   output logic               empty
);
   import ssids_pkg::*;
`include "assert_macros.svh"

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full  = count_ff == QCNT_W'(QUEUE_DEPTH);
      empty = count_ff == '0;
      head  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_NEVER(a_no_overrun, clock, reset, push && full)
   `ASSERT_NEVER(a_no_underrun, clock, reset, pop && empty)

endmodule

`default_nettype wire

[hdl/ssids_back.sv]
// back part: expands queued commands into result items, one per cycle unless the output stalls
// depends on ssids_pkg
`default_nettype none

module ssids_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  ssids_pkg::cmd_type     q_head,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_byte,
   output logic [ssids_pkg::LEN_W-1:0] rsp_len,
   output logic                   rsp_ovf,
   output logic                   rsp_last
);
   import ssids_pkg::*;

   cmd_type          work_ff, work_in;
   logic             work_vld_ff, work_vld_in;
   logic [2:0]       idx_ff, idx_in;

   logic             rsp_vld_ff;
   logic [1:0]       kind_ff;
   logic [7:0]       byte_ff;
   logic [LEN_W-1:0] len_ff;
   logic             ovf_ff;
   logic             last_ff;

   logic             in_pre, in_main, in_flush;
   logic             adv, done;
   logic [1:0]       item_kind;
   logic [7:0]       item_byte;
   logic [LEN_W-1:0] item_len;
   logic             item_ovf;
   logic             item_last;

   always_comb begin
      in_pre   = work_ff.pre_cnt != '0;
      in_main  = !in_pre && work_ff.main_vld;
      in_flush = !in_pre && !work_ff.main_vld && work_ff.flush_cnt != '0;

      item_kind = KIND_END;
      item_byte = '0;
      item_len  = '0;
      item_ovf  = 1'b0;
      item_last = 1'b1;
      if (in_pre) begin
         item_kind = work_ff.pre_dash ? KIND_NAME : KIND_CONTENT;
         item_byte = work_ff.pre_dash ? CH_DASH : opener_byte(idx_ff);
         item_last = work_ff.pre_cnt == 3'd1 && !work_ff.main_vld &&
                     work_ff.flush_cnt == '0 && !work_ff.end_mark;
      end else if (in_main) begin
         item_kind = work_ff.main_kind;
         item_byte = work_ff.main_byte;
         item_len  = work_ff.main_len;
         item_ovf  = work_ff.main_ovf;
         item_last = work_ff.flush_cnt == '0 && !work_ff.end_mark;
      end else if (in_flush) begin
         item_kind = KIND_CONTENT;
         item_byte = work_ff.flush_dash ? CH_DASH : opener_byte(idx_ff);
         item_last = work_ff.flush_cnt == 3'd1 && !work_ff.end_mark;
      end

      adv   = work_vld_ff && (!rsp_vld_ff || rsp_ready);
      done  = adv && item_last;
      q_pop = !q_empty && (!work_vld_ff || done);

      work_in     = work_ff;
      idx_in      = idx_ff;
      work_vld_in = work_vld_ff;
      if (adv) begin
         if (in_pre) begin
            work_in.pre_cnt = work_ff.pre_cnt - 3'd1;
            idx_in          = (work_ff.pre_cnt == 3'd1) ? 3'd0 : idx_ff + 3'd1;
         end else if (in_main) begin
            work_in.main_vld = 1'b0;
         end else if (in_flush) begin
            work_in.flush_cnt = work_ff.flush_cnt - 3'd1;
            idx_in            = idx_ff + 3'd1;
         end else begin
            work_in.end_mark = 1'b0;
         end
      end
      if (q_pop) begin
         work_in     = q_head;
         idx_in      = '0;
         work_vld_in = 1'b1;
      end else if (done) begin
         work_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         if (adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      if (adv) begin
         kind_ff <= item_kind;
         byte_ff <= item_byte;
         len_ff  <= item_len;
         ovf_ff  <= item_ovf;
         last_ff <= item_last;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_len   = len_ff;
   assign rsp_ovf   = ovf_ff;
   assign rsp_last  = last_ff;

endmodule

`default_nettype wire

[hdl/ssi_directive_scanner.sv]
// include-directive scanner: one content byte per item in, typed result items out
// throughput: 1 item per cycle while the command queue has a free slot; the back
//   end emits one result per cycle unless the output stalls, so items with
//   several results fill the queue until the back end catches up
// reset: synchronous active-high; scan state cleared, scanning enabled, queue empty
`default_nettype none

module ssi_directive_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // end_of_content
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [14:8] name_length,
                                          // [15] name_overflow
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,   // last_of_run
   // configuration: ssi_enable
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import ssids_pkg::*;

   // front <-> queue <-> back
   cmd_type          front_cmd;
   logic             front_push;
   logic             q_full;
   cmd_type          q_head;
   logic             q_empty;
   logic             q_pop;
   logic             req_accept;

   logic [LEN_W-1:0] rsp_len;
   logic             rsp_ovf;
   logic [7:0]       rsp_byte;

   // the front takes a byte whenever the queue has a free slot; a byte that
   // produces no results (mid-opener or held dash) never uses a slot
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   ssids_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_tdata),
      .in_eoc      (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (front_cmd),
      .cmd_vld     (front_push)
   );

   // commands wait here so the front keeps accepting while the back
   // is busy with multi-result items or stalled by the consumer
   ssids_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // back end walks each command and feeds the output register
   ssids_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_byte  (rsp_byte),
      .rsp_len   (rsp_len),
      .rsp_ovf   (rsp_ovf),
      .rsp_last  (rsp_tlast)
   );

   // pack result payload, out_byte in the low bits
   assign rsp_tdata = {rsp_ovf, rsp_len, rsp_byte};

endmodule

`default_nettype wire

[test/ssi_directive_scanner_chk.sv]
// result checker for the include-directive scanner: watches both streams,
// predicts every result item from the accepted input items and compares them
// depends on ssids_pkg for kinds, characters and the name limit
module ssi_directive_scanner_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          owed_cnt
);
   import ssids_pkg::*;

   // "<!--#", first byte lowest
   localparam logic [39:0] OPEN_SEQ = {CH_HASH, CH_DASH, CH_DASH, CH_BANG, CH_LT};

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data;
      logic [LEN_W-1:0] len;
      logic             ovf;
      logic             last;
   } scan_out_type;

   scan_out_type owed_q[$];
   scan_out_type run_q[$];

   logic        scan_en;
   logic        in_tag;
   int unsigned open_held;
   int unsigned dash_held;
   int unsigned name_cnt;
   logic        name_ovf;

   initial begin
      fail_count = 0;
      owed_cnt   = 0;
   end

   task automatic clear_scan();
      in_tag    = 1'b0;
      open_held = 0;
      dash_held = 0;
      name_cnt  = 0;
      name_ovf  = 1'b0;
   endtask

   task automatic put(input logic [1:0] kind, input logic [7:0] data,
                      input logic [LEN_W-1:0] len, input logic ovf);
      run_q.push_back('{kind, data, len, ovf, 1'b0});
   endtask

   // names past the limit are dropped and remembered as overflow
   task automatic put_name(input logic [7:0] data);
      if (name_cnt < NAME_MAX) begin
         name_cnt++;
         put(KIND_NAME, data, '0, 1'b0);
      end else begin
         name_ovf = 1'b1;
      end
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic eoc);
      run_q.delete();
      if (!scan_en) begin
         put(KIND_CONTENT, b, '0, 1'b0);
      end else if (in_tag) begin
         if (b == CH_DASH) begin
            if (dash_held < 2) dash_held++;
            else put_name(CH_DASH);
         end else if (b == CH_GT && dash_held == 2) begin
            put(KIND_CLOSE, 8'h00, name_cnt[LEN_W-1:0], name_ovf);
            clear_scan();
         end else begin
            repeat (dash_held) put_name(CH_DASH);
            dash_held = 0;
            put_name(b);
         end
      end else begin
         if (b == OPEN_SEQ[8*open_held +: 8]) begin
            if (open_held == 4) begin
               clear_scan();
               in_tag = 1'b1;
            end else begin
               open_held++;
            end
         end else begin
            for (int k = 0; k < open_held; k++) put(KIND_CONTENT, OPEN_SEQ[8*k +: 8], '0, 1'b0);
            if (b == CH_LT) begin
               open_held = 1;
            end else begin
               open_held = 0;
               put(KIND_CONTENT, b, '0, 1'b0);
            end
         end
      end
      // end of content flushes held bytes even while scanning is off
      if (eoc) begin
         if (in_tag) repeat (dash_held) put(KIND_CONTENT, CH_DASH, '0, 1'b0);
         else for (int k = 0; k < open_held; k++) put(KIND_CONTENT, OPEN_SEQ[8*k +: 8], '0, 1'b0);
         put(KIND_END, 8'h00, '0, 1'b0);
         clear_scan();
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[k]) owed_q.push_back(run_q[k]);
   endtask

   task automatic match_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      scan_out_type want;
      if (owed_q.size() == 0) begin
         $error("result item with nothing owed: kind %0d byte %0d", rsp_tuser, rsp_tdata[7:0]);
         fail_count++;
      end else begin
         want = owed_q.pop_front();
         match_field("kind", int'(want.kind), int'(rsp_tuser));
         match_field("out_byte", int'(want.data), int'(rsp_tdata[7:0]));
         match_field("name_length", int'(want.len), int'(rsp_tdata[14:8]));
         match_field("name_overflow", int'(want.ovf), int'(rsp_tdata[15]));
         match_field("last_of_run", int'(want.last), int'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_q.delete();
         scan_en = 1'b1;
         clear_scan();
      end else begin
         if (csr_wr_en) scan_en = csr_wr_data;
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      owed_cnt <= owed_q.size();
   end

endmodule

[test/ssi_directive_scanner_tb.sv]
// top of the include-directive scanner bench: clock, reset, byte stimulus,
// result back-pressure and the verdict
// depends on ssids_pkg, ssi_directive_scanner and ssi_directive_scanner_chk
module ssi_directive_scanner_tb;
   import ssids_pkg::*;

   // generous bound: ~530 items, each up to 6 results behind receiver stalls
   localparam int LIMIT_CYCLES  = 400000;
   // long receiver hold-off so the command queue fills and req_tready drops
   localparam int HOLD_CYCLES   = 300;
   // items that yield nothing may still be in flight when nothing is owed
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 10;
   localparam logic [39:0] OPEN_SEQ = {CH_HASH, CH_DASH, CH_DASH, CH_BANG, CH_LT};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;   // end_of_content
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_byte, [14:8] name_length, [15] name_overflow
   logic [1:0]  rsp_tuser;   // kind
   logic        rsp_tlast;   // last_of_run
   logic        csr_wr_en;
   logic        csr_wr_data; // ssi_enable

   int fail_count;
   int owed_cnt;
   int sent_cnt    = 0;
   int cycle_cnt   = 0;
   int req_gap_max = 14;
   int rsp_gap_max = 14;
   bit hold_rsp    = 1'b0;

   ssi_directive_scanner uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ssi_directive_scanner_chk scan_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .owed_cnt    (owed_cnt)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the stream hangs or results go missing
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // roughly one byte in forty ends the content
   function automatic bit rare_end();
      return ($urandom_range(0, 39) == 0);
   endfunction

   // name bytes lean on dashes and '>' to hit the closer corners
   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 7))
         0, 1:    return CH_DASH;
         2:       return CH_GT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // called and returns at a falling edge; valid is only lowered for a real gap,
   // so a back-to-back item keeps it high throughout
   task automatic send_byte(input logic [7:0] b, input bit eoc);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_cnt++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit eoc_on_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eoc_on_last && (i == s.len() - 1));
   endtask

   // directive with random name; sometimes a long name, sometimes
   // a short or extra-long dash run before '>'
   task automatic send_directive();
      int name_len;
      int dashes;
      for (int i = 0; i < 5; i++) send_byte(OPEN_SEQ[8*i +: 8], rare_end());
      name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
      repeat (name_len) send_byte(name_char(), rare_end());
      dashes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 3);
      repeat (dashes) send_byte(CH_DASH, rare_end());
      send_byte(CH_GT, rare_end());
   endtask

   // opener prefix cut off by an arbitrary byte
   task automatic send_broken_opener();
      int held;
      held = $urandom_range(1, 4);
      for (int i = 0; i < held; i++) send_byte(OPEN_SEQ[8*i +: 8], rare_end());
      send_byte(8'($urandom_range(0, 255)), rare_end());
   endtask

   task automatic random_phase(input int count);
      int target;
      target = sent_cnt + count;
      while (sent_cnt < target) begin
         // a quarter of the segments run without idling on that side
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_directive();
            5, 6:          send_broken_opener();
            default:       repeat ($urandom_range(1, 4))
                              send_byte(8'($urandom_range(0, 255)), rare_end());
         endcase
      end
   endtask

   // register write only once the scanner has gone quiet
   task automatic set_scanning(input logic en);
      req_tvalid <= 1'b0;
      while (owed_cnt != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= en;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // receiver: random stall per item, plus one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte extremes, end marker behind a byte, failed opener with '<' restart,
      // directive with a failed closer and a third dash, held opener released by a mismatch
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("<<!-x", 1'b0);
      send_text("<!--#a--x--->", 1'b0);
      send_text("<!--z", 1'b1);

      set_scanning(1'b1);
      random_phase(150);

      // pass-through, held scan state carried across
      set_scanning(1'b0);
      random_phase(80);

      // back-pressure: receiver holds while bytes keep coming with no gaps
      set_scanning(1'b1);
      hold_rsp    = 1'b1;
      req_gap_max = 0;
      repeat (6) send_directive();
      random_phase(150);

      req_tvalid <= 1'b0;
      while (owed_cnt != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
